// File: rtl/klb_pkg.sv
// ----------------------------------------------------------------------------
// klb_pkg
// Shared types and fixed field widths for the k-th ancestor jump-table block.
// ----------------------------------------------------------------------------
package klb_pkg;

  localparam int NODE_W   = 10;
  localparam int STEPS_W  = 10;
  localparam int STATUS_W = 2;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_NONE    = 2'd1,
    ST_FULL    = 2'd2,
    ST_UNKNOWN = 2'd3
  } status_e;

  typedef enum logic {
    CMD_ADD   = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ADD,
    S_QRY,
    S_DONE
  } state_e;

  // finished result handed from the sequencer to the output register
  typedef struct packed {
    logic              valid;
    logic [NODE_W-1:0] node;
    status_e           status;
  } res_t;

endpackage

// File: rtl/klb_ram.sv
// ----------------------------------------------------------------------------
// klb_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module klb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/klb_engine.sv
// ----------------------------------------------------------------------------
// klb_engine
// Sequencer for add and query items: fills a new node's jump row one level per
// cycle and climbs the table by the set bits of the step count.
// ----------------------------------------------------------------------------
module klb_engine #(
  parameter int MAX_NODES = 1024,
  parameter int LEVELS    = 10,
  localparam int IDX_W  = $clog2(MAX_NODES),
  localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1,
  localparam int ENT_W  = IDX_W + 1,
  localparam int ADDR_W = IDX_W + LVL_W
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    cmd_i,
  input  logic [klb_pkg::NODE_W-1:0]  node_i,
  input  logic                    has_parent_i,
  input  logic [klb_pkg::STEPS_W-1:0] steps_i,
  output klb_pkg::res_t           res_o,
  input  logic                    res_ready_i,
  output logic                    mem_we_o,
  output logic [ADDR_W-1:0]       mem_waddr_o,
  output logic [ENT_W-1:0]        mem_wdata_o,
  output logic                    mem_re_o,
  output logic [ADDR_W-1:0]       mem_raddr_o,
  input  logic [ENT_W-1:0]        mem_rdata_i
);
  import klb_pkg::*;

  localparam int CNT_W  = $clog2(MAX_NODES + 1);
  localparam int LCNT_W = $clog2(LEVELS + 1);
  localparam int CMP_W  = (CNT_W > NODE_W) ? CNT_W : NODE_W;

  state_e              state_q, state_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [LCNT_W-1:0]   lvl_q, lvl_d;
  logic                rd_pend_q, rd_pend_d;
  logic [IDX_W-1:0]    x_q, x_d;
  logic [STEPS_W-1:0]  steps_q, steps_d;
  logic [NODE_W-1:0]   res_node_q, res_node_d;
  status_e             res_status_q, res_status_d;

  logic             full;
  logic             unknown;
  logic             hi_steps;
  logic [IDX_W-1:0] child;
  logic [IDX_W-1:0] node_idx;
  logic [ENT_W-1:0] entry;
  logic [IDX_W-1:0] x_cur;
  logic             lvl_end;

  assign full     = (count_q == CNT_W'(MAX_NODES));
  assign unknown  = (CMP_W'(node_i) >= CMP_W'(count_q));
  assign hi_steps = ((steps_i >> LEVELS) != '0);
  assign child    = count_q[IDX_W-1:0];
  assign node_idx = IDX_W'(node_i);
  assign lvl_end  = (lvl_q == LCNT_W'(LEVELS));
  // entry read last cycle, or absent when nothing was read
  assign entry    = rd_pend_q ? mem_rdata_i : '0;
  assign x_cur    = rd_pend_q ? mem_rdata_i[IDX_W-1:0] : x_q;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    lvl_d        = lvl_q;
    rd_pend_d    = 1'b0;
    x_d          = x_q;
    steps_d      = steps_q;
    res_node_d   = res_node_q;
    res_status_d = res_status_q;
    mem_we_o     = 1'b0;
    mem_waddr_o  = '0;
    mem_wdata_o  = '0;
    mem_re_o     = 1'b0;
    mem_raddr_o  = '0;
    res_o        = '{valid: 1'b0, node: res_node_q, status: res_status_q};

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          res_node_d = '0;
          if (cmd_e'(cmd_i) == CMD_ADD) begin
            if (full) begin
              res_status_d = ST_FULL;
              state_d      = S_DONE;
            end else if (has_parent_i && unknown) begin
              res_status_d = ST_UNKNOWN;
              state_d      = S_DONE;
            end else begin
              // level 0 is the parent itself
              mem_we_o    = 1'b1;
              mem_waddr_o = {child, LVL_W'(0)};
              mem_wdata_o = has_parent_i ? {1'b1, node_idx} : '0;
              mem_re_o    = has_parent_i;
              mem_raddr_o = {node_idx, LVL_W'(0)};
              rd_pend_d   = has_parent_i;
              lvl_d       = LCNT_W'(1);
              state_d     = S_ADD;
            end
          end else begin
            if (unknown) begin
              res_status_d = ST_UNKNOWN;
              state_d      = S_DONE;
            end else if (hi_steps) begin
              res_status_d = ST_NONE;
              state_d      = S_DONE;
            end else begin
              x_d     = node_idx;
              steps_d = steps_i;
              lvl_d   = '0;
              state_d = S_QRY;
            end
          end
        end
      end

      S_ADD: begin
        if (lvl_end) begin
          count_d      = count_q + CNT_W'(1);
          res_node_d   = NODE_W'(child);
          res_status_d = ST_OK;
          state_d      = S_DONE;
        end else begin
          // ancestor rows lie below the child row, so no read/write overlap
          mem_we_o    = 1'b1;
          mem_waddr_o = {child, lvl_q[LVL_W-1:0]};
          mem_wdata_o = entry;
          mem_re_o    = entry[IDX_W];
          mem_raddr_o = {entry[IDX_W-1:0], lvl_q[LVL_W-1:0]};
          rd_pend_d   = entry[IDX_W];
          lvl_d       = lvl_q + LCNT_W'(1);
        end
      end

      S_QRY: begin
        if (rd_pend_q && !mem_rdata_i[IDX_W]) begin
          res_node_d   = '0;
          res_status_d = ST_NONE;
          state_d      = S_DONE;
        end else if (lvl_end) begin
          res_node_d   = NODE_W'(x_cur);
          res_status_d = ST_OK;
          state_d      = S_DONE;
        end else begin
          mem_re_o    = steps_q[0];
          mem_raddr_o = {x_cur, lvl_q[LVL_W-1:0]};
          rd_pend_d   = steps_q[0];
          x_d         = x_cur;
          steps_d     = steps_q >> 1;
          lvl_d       = lvl_q + LCNT_W'(1);
        end
      end

      S_DONE: begin
        res_o.valid = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      lvl_q     <= '0;
      rd_pend_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      lvl_q     <= lvl_d;
      rd_pend_q <= rd_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q          <= x_d;
    steps_q      <= steps_d;
    res_node_q   <= res_node_d;
    res_status_q <= res_status_d;
  end

endmodule

// File: rtl/kth_ancestor_binary_lifting.sv
// ----------------------------------------------------------------------------
// kth_ancestor_binary_lifting
// Binary-lifting jump table for a growing tree: add nodes, query k-th ancestor.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  in      | input     | in_valid_i / in_stall_o   | cmd_i node_i has_parent_i steps_i
//  out     | output    | out_valid_o / out_stall_i | node_out_o status_o
//
//  add: writes one jump-table level per cycle, level 0 at accept
//  query: an absent entry ends the climb early
//  errors found at accept (full table, unknown node, step bit too high) skip the table
//  one item in flight; the next is taken once the result moves to the output
//  register, even while that register is stalled
//  reset clears the node count and control state, not the table; rows are written before they are read
// ----------------------------------------------------------------------------
module kth_ancestor_binary_lifting #(
  parameter int MAX_NODES = 1024,
  parameter int LEVELS    = 10
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        cmd_i,
  input  logic [klb_pkg::NODE_W-1:0]  node_i,
  input  logic                        has_parent_i,
  input  logic [klb_pkg::STEPS_W-1:0] steps_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [klb_pkg::NODE_W-1:0]  node_out_o,
  output logic [klb_pkg::STATUS_W-1:0] status_o
);
  import klb_pkg::*;

  localparam int IDX_W  = $clog2(MAX_NODES);
  localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int ENT_W  = IDX_W + 1;
  localparam int ADDR_W = IDX_W + LVL_W;
  localparam int DEPTH  = MAX_NODES << LVL_W;

  res_t              res;
  logic              res_ready;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [ENT_W-1:0]  mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  logic [ENT_W-1:0]  mem_rdata;

  logic                out_valid_q, out_valid_d;
  logic [NODE_W-1:0]   out_node_q;
  logic [STATUS_W-1:0] out_status_q;

  klb_engine #(
    .MAX_NODES (MAX_NODES),
    .LEVELS    (LEVELS)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cmd_i        (cmd_i),
    .node_i       (node_i),
    .has_parent_i (has_parent_i),
    .steps_i      (steps_i),
    .res_o        (res),
    .res_ready_i  (res_ready),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_re_o     (mem_re),
    .mem_raddr_o  (mem_raddr),
    .mem_rdata_i  (mem_rdata)
  );

  // row = node index, column = level
  klb_ram #(
    .WIDTH (ENT_W),
    .DEPTH (DEPTH)
  ) u_jump_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // output slot is free when empty or being taken this cycle
  assign res_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res.valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid && res_ready) begin
      out_node_q   <= res.node;
      out_status_q <= STATUS_W'(res.status);
    end
  end

  assign out_valid_o = out_valid_q;
  assign node_out_o  = out_node_q;
  assign status_o    = out_status_q;

endmodule

// File: rtl/klb_checker.sv
// ----------------------------------------------------------------------------
// klb_checker
// Port-level checks on the k-th ancestor block, bound to the top level.
// ----------------------------------------------------------------------------
module klb_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [klb_pkg::NODE_W-1:0]   node_out_o,
  input logic [klb_pkg::STATUS_W-1:0] status_o
);
  import klb_pkg::*;

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(node_out_o) && $stable(status_o))
    else $error("stalled result changed");

  // every error result reports index zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != STATUS_W'(ST_OK)) |-> node_out_o == '0)
    else $error("error result with nonzero index");

  // one item at a time: busy right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second item taken while one is in flight");

  // a result never appears in the cycle right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !out_valid_o |=> !out_valid_o)
    else $error("result appeared without work time");

endmodule

bind kth_ancestor_binary_lifting klb_checker u_klb_checker (.*);
